FILE: design/pcc_pkg.sv
// Package for the pendulum cart controller: mode codes, register indexes,
// fixed constants and the command/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pcc_pkg;

   // operating modes
   localparam logic [1:0] MODE_HOMING  = 2'd0;
   localparam logic [1:0] MODE_SWING   = 2'd1;
   localparam logic [1:0] MODE_UPRIGHT = 2'd2;

   // register indexes
   localparam logic [2:0] REG_PEND_ZERO      = 3'd0;
   localparam logic [2:0] REG_UPRIGHT_OFFSET = 3'd1;
   localparam logic [2:0] REG_GAIN_P         = 3'd2;
   localparam logic [2:0] REG_GAIN_D         = 3'd3;
   localparam logic [2:0] REG_START_MODE     = 3'd4;

   localparam logic [15:0] UPRIGHT_OFFSET_RESET = 16'd45990;
   localparam logic [15:0] GAIN_P_RESET         = 16'd2048;
   localparam logic [15:0] GAIN_D_RESET         = 16'd128;

   // divider width: dividend magnitude below 2^25, divisor 33 bits
   localparam int DIV_STEPS = 25;

   // datapath commands from the controller
   typedef struct packed {
      logic load;       // latch input item, compute angle stage
      logic prep;       // compute dividend and divisor
      logic div_step;   // one restoring-division step
      logic mul_p;      // product gain_p * a
      logic mul_d;      // product gain_d * q, accumulate
      logic finish;     // mode logic, state update, output register
   } pcc_cmd_type;

   typedef struct packed {
      logic dt_zero;    // elapsed time is zero
   } pcc_status_type;

endpackage
`default_nettype wire

FILE: design/pcc_ctrl.sv
// Controller state machine: sequences one item through the datapath.
// Depends on pcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcc_ctrl
   import pcc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic           rsp_pending,
   input  wire pcc_status_type status,
   output pcc_cmd_type         cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PREP = 6'b000010,
      ST_DIV  = 6'b000100,
      ST_MULP = 6'b001000,
      ST_MULD = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_pending;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (status.dt_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.prep = 1'b1;
               cnt_in   = 5'(DIV_STEPS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == 5'd0) state_in = ST_MULP;
            else cnt_in = cnt_ff - 5'd1;
         end
         ST_MULP: begin
            cmd.mul_p = 1'b1;
            state_in  = ST_MULD;
         end
         ST_MULD: begin
            cmd.mul_d = 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/pcc_datapath.sv
// Datapath: angle wrap, serial divider for the speed, shared multiplier
// for the PD law, mode logic and state. Depends on pcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcc_datapath
   import pcc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pcc_cmd_type        cmd,
   output pcc_status_type          status,
   input  wire logic [31:0]        req_now_ms,
   input  wire logic [11:0]        req_raw_angle,
   input  wire logic signed [15:0] req_cart_pos,
   input  wire logic [11:0]        pend_zero,
   input  wire logic [15:0]        upright_offset,
   input  wire logic [15:0]        gain_p,
   input  wire logic [15:0]        gain_d,
   input  wire logic               mode_load,
   input  wire logic [1:0]         mode_value,
   output logic                    out_load,
   output logic [7:0]              out_rev,
   output logic [7:0]              out_fwd,
   output logic [1:0]              out_mode
);

   // state of the controller
   logic [31:0]        last_time_ff;
   logic signed [16:0] prev_angle_ff;
   logic signed [31:0] prev_speed_ff;
   logic [1:0]         cur_mode_ff;
   logic signed [8:0]  swing_drive_ff;
   logic [31:0]        swing_time_ff;

   // per-item registers
   logic [31:0]        now_ff;
   logic signed [15:0] cart_ff;
   logic [31:0]        dt_ff;
   logic signed [16:0] a_ff;
   logic [24:0]        quo_ff;
   logic [32:0]        rem_ff;
   logic [32:0]        dvs_ff;
   logic               neg_ff;
   logic signed [33:0] q_ff;
   logic signed [51:0] acc_ff;

   // angle: wrap raw difference, scale by 45/2, subtract offset, wrap again
   logic signed [13:0] d0, d1;
   logic signed [19:0] d45;
   logic signed [18:0] ah;
   logic signed [19:0] a0, a1;
   always_comb begin
      d0 = $signed({2'b00, req_raw_angle}) - $signed({2'b00, pend_zero});
      d1 = d0;
      if (d0 > 14'sd2048) d1 = d0 - 14'sd4096;
      if (d0 < -14'sd2048) d1 = d0 + 14'sd4096;
      d45 = 20'(d1) * 20'sd45;
      ah  = 19'(d45 >>> 1);
      a0  = 20'(ah) - $signed({4'b0, upright_offset});
      a1  = a0;
      if (a0 > 20'sd46080) a1 = a0 - 20'sd92160;
      if (a0 < -20'sd46080) a1 = a0 + 20'sd92160;
   end

   assign status.dt_zero = (dt_ff == 32'd0);

   // dividend (a - prev)*125, divisor 2*dt
   logic signed [17:0] diff;
   logic signed [25:0] num;
   assign diff = 18'(a_ff) - 18'(prev_angle_ff);
   assign num  = 26'(diff) * 26'sd125;

   // one restoring-division step
   logic [32:0] rem_sh;
   logic [33:0] rem_try;
   assign rem_sh  = {rem_ff[31:0], quo_ff[24]};
   assign rem_try = {1'b0, rem_sh} - {1'b0, dvs_ff};

   // saturated speed
   logic signed [31:0] q_sat;
   always_comb begin
      if (q_ff > 34'sh07FFFFFFF) q_sat = 32'sh7FFFFFFF;
      else if (q_ff < -34'sh080000000) q_sat = 32'sh80000000;
      else q_sat = 32'(q_ff);
   end

   // shared multiplier: 17x17 or 32x17 signed
   logic signed [16:0] aa_abs;
   logic signed [48:0] prod;
   assign aa_abs = (a_ff < 0) ? -a_ff : a_ff;
   always_comb begin
      if (cmd.mul_p) prod = 49'($signed({1'b0, gain_p}) * a_ff);
      else           prod = 49'($signed({1'b0, gain_d}) * q_sat);
   end

   // balance duty
   logic [51:0] umag;
   logic [35:0] pfull;
   logic [8:0]  pd;
   logic [7:0]  bduty;
   always_comb begin
      umag  = acc_ff[51] ? 52'(-acc_ff) : 52'(acc_ff);
      pfull = umag[51:16];
      pd    = (pfull > 36'd255) ? 9'd255 : 9'(pfull);
      if (pd < 9'd78) bduty = 8'd130;
      else if (pd + 9'd130 > 9'd255) bduty = 8'd255;
      else bduty = 8'(pd + 9'd130);
   end

   // mode logic
   logic [1:0]        mode_n;
   logic signed [8:0] sw_n;
   logic [31:0]       swt_n;
   logic [7:0]        rev_n, fwd_n;
   logic [31:0]       since;
   always_comb begin
      mode_n = cur_mode_ff;
      sw_n   = swing_drive_ff;
      swt_n  = swing_time_ff;
      rev_n  = 8'd0;
      fwd_n  = 8'd0;
      since  = now_ff - swing_time_ff;
      if ((cart_ff < 16'sd250 && cart_ff > 16'sd48) || cur_mode_ff == MODE_HOMING) begin
         case (cur_mode_ff)
            MODE_HOMING: begin
               if (cart_ff < 16'sd132) fwd_n = 8'd150;
               else mode_n = MODE_SWING;
            end
            MODE_SWING: begin
               if (aa_abs < 17'sd40960) begin
                  if (prev_speed_ff > 0 && q_sat <= 0) sw_n = -9'sd150;
                  else if (prev_speed_ff < 0 && q_sat >= 0) sw_n = 9'sd150;
               end
               if (since >= 32'd20) begin
                  swt_n = now_ff;
                  if (sw_n > 0) sw_n = sw_n - 9'sd1;
                  else if (sw_n < 0) sw_n = sw_n + 9'sd1;
               end
               if (sw_n > 0) fwd_n = 8'(sw_n);
               else if (sw_n < 0) rev_n = 8'(-sw_n);
            end
            default: begin
               if (acc_ff > 52'sd196608) fwd_n = bduty;
               else if (acc_ff < -52'sd196608) rev_n = bduty;
            end
         endcase
      end
   end

   // per-item registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff  <= req_now_ms;
         cart_ff <= req_cart_pos;
         dt_ff   <= req_now_ms - last_time_ff;
         a_ff    <= 17'(a1);
      end
      if (cmd.prep) begin
         neg_ff <= num[25];
         quo_ff <= num[25] ? 25'(-num) : 25'(num);
         rem_ff <= '0;
         dvs_ff <= {dt_ff, 1'b0};
      end
      if (cmd.div_step) begin
         if (!rem_try[33]) begin
            rem_ff <= rem_try[32:0];
            quo_ff <= {quo_ff[23:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[23:0], 1'b0};
         end
      end
      if (cmd.mul_p) begin
         q_ff   <= neg_ff ? -$signed({9'b0, quo_ff}) : $signed({9'b0, quo_ff});
         acc_ff <= (aa_abs < 17'sd11520) ? 52'(prod) : '0;
      end
      if (cmd.mul_d && aa_abs < 17'sd11520) begin
         acc_ff <= acc_ff + (52'(prod) <<< 4);
      end
   end

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff   <= '0;
         prev_angle_ff  <= '0;
         prev_speed_ff  <= '0;
         cur_mode_ff    <= MODE_HOMING;
         swing_drive_ff <= '0;
         swing_time_ff  <= '0;
         out_load       <= 1'b0;
      end else begin
         out_load <= cmd.finish;
         if (mode_load) cur_mode_ff <= mode_value;
         if (cmd.prep) last_time_ff <= now_ff;
         if (cmd.finish) begin
            prev_angle_ff  <= a_ff;
            prev_speed_ff  <= q_sat;
            cur_mode_ff    <= mode_n;
            swing_drive_ff <= sw_n;
            swing_time_ff  <= swt_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_rev  <= rev_n;
         out_fwd  <= fwd_n;
         out_mode <= mode_n;
      end
   end

endmodule
`default_nettype wire

FILE: design/pendulum_cart_controller.sv
// Top level of the pendulum cart controller: register port, output stage,
// controller and datapath. Depends on pcc_pkg, pcc_ctrl, pcc_datapath.
`timescale 1ns / 1ps
`default_nettype none
// One item is one control step. An item with nonzero elapsed time passes
// through a setup state, 25 steps of the serial divider that forms the
// pendulum speed, the shared multiplier for the PD law (P term, then D
// term) and a finish state that loads the output register; rsp_valid is
// registered from that load. An item with zero elapsed time gives no
// result and returns the block to idle from the setup state. Items
// are handled one at a time; the result waits in an output register, and a
// new item is taken once that register is empty.
module pendulum_cart_controller
   import pcc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [31:0]        req_now_ms,
   input  wire logic [11:0]        req_raw_angle,
   input  wire logic signed [15:0] req_cart_pos,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_duty_reverse,
   output logic [7:0]              rsp_duty_forward,
   output logic [1:0]              rsp_mode,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   logic [11:0] pend_zero_ff;
   logic [15:0] upright_ff, gain_p_ff, gain_d_ff;
   logic [1:0]  start_mode_ff;
   logic        csr_we, mode_load;
   logic [1:0]  mode_value;
   logic [2:0]  reg_idx;

   assign pready     = 1'b1;
   assign csr_we     = psel && penable && pwrite;
   assign reg_idx    = paddr[4:2];
   assign mode_value = (pwdata[1:0] == 2'd3) ? MODE_UPRIGHT : pwdata[1:0];
   assign mode_load  = csr_we && reg_idx == REG_START_MODE;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_zero_ff  <= '0;
         upright_ff    <= UPRIGHT_OFFSET_RESET;
         gain_p_ff     <= GAIN_P_RESET;
         gain_d_ff     <= GAIN_D_RESET;
         start_mode_ff <= MODE_HOMING;
      end else if (csr_we) begin
         case (reg_idx)
            REG_PEND_ZERO:      pend_zero_ff  <= pwdata[11:0];
            REG_UPRIGHT_OFFSET: upright_ff    <= pwdata[15:0];
            REG_GAIN_P:         gain_p_ff     <= pwdata[15:0];
            REG_GAIN_D:         gain_d_ff     <= pwdata[15:0];
            REG_START_MODE:     start_mode_ff <= mode_value;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PEND_ZERO:      prdata = {20'd0, pend_zero_ff};
         REG_UPRIGHT_OFFSET: prdata = {16'd0, upright_ff};
         REG_GAIN_P:         prdata = {16'd0, gain_p_ff};
         REG_GAIN_D:         prdata = {16'd0, gain_d_ff};
         REG_START_MODE:     prdata = {30'd0, start_mode_ff};
         default:            prdata = '0;
      endcase
   end

   pcc_cmd_type    cmd;
   pcc_status_type status;
   logic           out_load;
   logic [7:0]     out_rev, out_fwd;
   logic [1:0]     out_mode;
   logic           rsp_valid_ff;

   // output register busy from its load until the item is taken
   pcc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_pending (rsp_valid_ff || out_load),
      .status      (status),
      .cmd         (cmd)
   );

   pcc_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_now_ms     (req_now_ms),
      .req_raw_angle  (req_raw_angle),
      .req_cart_pos   (req_cart_pos),
      .pend_zero      (pend_zero_ff),
      .upright_offset (upright_ff),
      .gain_p         (gain_p_ff),
      .gain_d         (gain_d_ff),
      .mode_load      (mode_load),
      .mode_value     (mode_value),
      .out_load       (out_load),
      .out_rev        (out_rev),
      .out_fwd        (out_fwd),
      .out_mode       (out_mode)
   );

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duty_reverse = out_rev;
   assign rsp_duty_forward = out_fwd;
   assign rsp_mode         = out_mode;

endmodule
`default_nettype wire

FILE: sim/pendulum_cart_controller_tb.sv
// Self-checking bench for the pendulum cart controller: a control-law predictor feeds a
// scoreboard class, random control steps with random stalls and register phases.
// Depends on pcc_pkg and the pendulum_cart_controller RTL.
`timescale 1ns / 1ps
module pendulum_cart_controller_tb
   import pcc_pkg::*;
();

   typedef struct packed {
      logic [7:0] duty_reverse;
      logic [7:0] duty_forward;
      logic [1:0] mode;
   } duty_type;

   // scoreboard of expected duties
   class duty_board;
      duty_type pending[$];
      int errors = 0;
      function void note(duty_type d);
         pending.push_back(d);
      endfunction
      function void check(duty_type got);
         duty_type exp_d;
         if (pending.size() == 0) begin
            $display("%0t unexpected item: got %h", $realtime, got);
            errors++;
            return;
         end
         exp_d = pending.pop_front();
         if (got.duty_reverse !== exp_d.duty_reverse)
            $display("%0t duty_reverse exp %0d got %0d", $realtime, exp_d.duty_reverse,
                     got.duty_reverse);
         if (got.duty_forward !== exp_d.duty_forward)
            $display("%0t duty_forward exp %0d got %0d", $realtime, exp_d.duty_forward,
                     got.duty_forward);
         if (got.mode !== exp_d.mode)
            $display("%0t mode exp %0d got %0d", $realtime, exp_d.mode, got.mode);
         if (got !== exp_d) errors++;
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0;
   logic [31:0] req_now_ms = 0;
   logic [11:0] req_raw_angle = 0;
   logic signed [15:0] req_cart_pos = 0;
   logic req_ready, rsp_valid, pready;
   logic [7:0] rsp_duty_reverse, rsp_duty_forward;
   logic [1:0] rsp_mode;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [4:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;

   pendulum_cart_controller dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor copy of registers and state
   logic [11:0] pz;
   logic [15:0] uoff, gp, gd;
   logic [1:0] smode, cmode;
   logic [31:0] t_last, t_swing;
   longint ang_prev, spd_prev, kick;

   duty_board board = new();
   bit quiet = 0;
   int idle_cnt = 0;

   function automatic logic [7:0] pd_duty(longint u);
      longint mag, p;
      mag = u < 0 ? -u : u;
      p = mag / 65536;
      if (p > 255) p = 255;
      if (p < 78) return 8'd130;
      p += 130;
      return p > 255 ? 8'd255 : 8'(p);
   endfunction

   function automatic void predict_step(logic [31:0] now, logic [11:0] raw,
                                        logic signed [15:0] cart);
      logic [31:0] dt;
      longint d, a, aa, q, u;
      duty_type r;
      dt = now - t_last;
      if (dt == 0) return;
      t_last = now;
      r = '0;
      d = longint'(raw) - longint'(pz);
      if (d > 2048) d -= 4096;
      if (d < -2048) d += 4096;
      d = d * 45;
      a = (d - (d < 0 ? 1 : 0)) / 2 - longint'(uoff);
      if (a > 46080) a -= 92160;
      if (a < -46080) a += 92160;
      q = (a - ang_prev) * 125 / (2 * longint'(dt));
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      ang_prev = a;
      aa = a < 0 ? -a : a;
      u = 0;
      if (aa < 11520) u = longint'(gp) * a + 16 * longint'(gd) * q;
      if ((cart < 250 && cart > 48) || cmode == MODE_HOMING) begin
         if (cmode == MODE_HOMING) begin
            if (cart < 132) r.duty_forward = 150;
            else cmode = MODE_SWING;
         end else if (cmode == MODE_SWING) begin
            if (aa < 40960) begin
               if (spd_prev > 0 && q <= 0) kick = -150;
               else if (spd_prev < 0 && q >= 0) kick = 150;
            end
            if (now - t_swing >= 20) begin
               t_swing = now;
               if (kick > 0) kick--;
               else if (kick < 0) kick++;
            end
            if (kick > 0) r.duty_forward = 8'(kick);
            else if (kick < 0) r.duty_reverse = 8'(-kick);
         end else begin
            if (u > 3 * 65536) r.duty_forward = pd_duty(u);
            else if (u < -3 * 65536) r.duty_reverse = pd_duty(u);
         end
      end
      spd_prev = q;
      r.mode = cmode;
      board.note(r);
   endfunction

   // result side: random stall bursts, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check({rsp_duty_reverse, rsp_duty_forward, rsp_mode});
   end
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 16);
            rsp_ready <= 0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1;
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (psel && penable)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt > 5000) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         REG_PEND_ZERO:      pz = val[11:0];
         REG_UPRIGHT_OFFSET: uoff = val[15:0];
         REG_GAIN_P:         gp = val[15:0];
         REG_GAIN_D:         gd = val[15:0];
         REG_START_MODE: begin
            smode = (val[1:0] == 2'd3) ? MODE_UPRIGHT : val[1:0];
            cmode = smode;
         end
         default: ;
      endcase
   endtask

   // drop valid, wait until all results are in, then let the block settle
   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // valid stays high into the next item unless an idle burst comes first
   task automatic send_step(logic [31:0] now, logic [11:0] raw, logic [15:0] cart);
      int n;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 16);
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1; req_now_ms <= now; req_raw_angle <= raw; req_cart_pos <= cart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_step(now, raw, cart);
      @(negedge clock);
   endtask

   logic [31:0] tnow;

   // a run of steps: mostly small time increments, angle mostly drifting, with occasional random jumps
   task automatic random_run(int count);
      logic [11:0] ang;
      logic [15:0] cart;
      int k;
      ang = 12'($urandom);
      cart = 16'($urandom_range(40, 260));
      for (k = 0; k < count; k++) begin
         case ($urandom_range(0, 9))
            0: tnow = $urandom;
            1: ;
            2: tnow += $urandom_range(1, 60);
            default: tnow += $urandom_range(1, 12);
         endcase
         if ($urandom_range(0, 9) == 0) ang = 12'($urandom);
         else ang += 12'($urandom_range(0, 120) - 60);
         if ($urandom_range(0, 9) == 0) cart = 16'($urandom);
         else if ($urandom_range(0, 3) == 0) cart = 16'($urandom_range(30, 270));
         send_step(tnow, ang, cart);
      end
   endtask

   initial begin
      int ph;
      pz = 0; uoff = UPRIGHT_OFFSET_RESET; gp = GAIN_P_RESET; gd = GAIN_D_RESET;
      smode = MODE_HOMING; cmode = MODE_HOMING;
      t_last = 0; t_swing = 0; ang_prev = 0; spd_prev = 0; kick = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: zero dt, field extremes, centering handoff
      send_step(0, 0, 0);
      send_step(1, 0, 16'sh8000);
      send_step(2, 12'hfff, 16'sh7fff);
      send_step(32'hffffffff, 12'h800, 131);
      send_step(32'hffffffff, 12'h800, 131);
      send_step(5, 12'h801, 132);
      send_step(25, 12'h7ff, 100);
      send_step(26, 12'h000, 48);
      send_step(27, 12'hfff, 250);
      drain();
      write_reg(REG_START_MODE, 3);
      write_reg(REG_UPRIGHT_OFFSET, 0);
      write_reg(REG_GAIN_P, 16'hffff);
      write_reg(REG_GAIN_D, 16'hffff);
      write_reg(REG_PEND_ZERO, 12'hfff);
      tnow = 100;
      send_step(tnow, 12'hfff, 100);
      send_step(tnow + 1, 12'h000, 100);
      send_step(tnow + 2, 12'h7ff, 100);
      send_step(tnow + 3, 12'h802, 100);
      send_step(tnow + 4, 12'hffe, 49);
      send_step(tnow + 5, 12'h001, 249);
      tnow += 5;
      drain();
      write_reg(3'd7, 32'hffffffff);
      write_reg(REG_START_MODE, MODE_SWING);
      write_reg(REG_PEND_ZERO, 0);
      write_reg(REG_UPRIGHT_OFFSET, 46080);
      write_reg(REG_GAIN_P, 0);
      write_reg(REG_GAIN_D, 0);
      send_step(tnow + 1, 12'h400, 100);
      send_step(tnow + 2, 12'hc00, 100);
      tnow += 2;
      drain();

      // random phases, each with fresh register settings
      for (ph = 0; ph < 12; ph++) begin
         if (ph == 11) quiet = 1;
         case (ph % 4)
            0: begin
               write_reg(REG_UPRIGHT_OFFSET, UPRIGHT_OFFSET_RESET);
               write_reg(REG_PEND_ZERO, $urandom_range(0, 4095));
            end
            1: write_reg(REG_UPRIGHT_OFFSET, $urandom_range(0, 46080));
            2: write_reg(REG_PEND_ZERO, $urandom_range(0, 4095));
            default: write_reg(REG_UPRIGHT_OFFSET, $urandom_range(44000, 46080));
         endcase
         write_reg(REG_GAIN_P, ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom));
         write_reg(REG_GAIN_D, ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom));
         write_reg(REG_START_MODE, $urandom_range(0, 3));
         random_run(100);
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
